// ----- src/kvft_pkg.sv -----
// shared types and character codes for the key/value frame table
`timescale 1ns / 1ps

package kvft_pkg;

    localparam int NAME_W     = 64;
    localparam int VALUE_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int NAME_LEN_W = 4;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;

    localparam logic [BYTE_W-1:0] CHR_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CHR_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CHR_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CHR_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NUL    = 8'h00;

    // one record handed from the parser to the table engine
    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [VALUE_W-1:0] value;
    } kvft_req_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [NAME_W-1:0]  name;
    } kvft_entry_t;

endpackage

// ----- src/kvft_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module kvft_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/kvft_front.sv -----
// frame parser: collects names and values, emits a record at each semicolon inside a frame
`timescale 1ns / 1ps

module kvft_front
    import kvft_pkg::*;
#(
    parameter int NAME_CHARS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              push,
    output kvft_req_t         push_data,
    input  logic              q_full
);

    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_NAME,
        MODE_VALUE
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [NAME_W-1:0]     name_accum_reg, name_accum_next;
    logic [NAME_LEN_W-1:0] name_len_reg, name_len_next;
    logic [NAME_W-1:0]     captured_reg, captured_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic                  accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign push_data.name  = captured_reg;
    assign push_data.value = value_reg;

    // byte classification and parse state update
    always_comb begin
        mode_next       = mode_reg;
        name_accum_next = name_accum_reg;
        name_len_next   = name_len_reg;
        captured_next   = captured_reg;
        value_next      = value_reg;
        push            = 1'b0;
        if (accept) begin
            case (mode_reg)
                MODE_OUTSIDE: begin
                    if (s_rx_byte == CHR_LBRACK) begin
                        mode_next       = MODE_NAME;
                        name_accum_next = '0;
                        name_len_next   = '0;
                        captured_next   = '0;
                        value_next      = '0;
                    end
                end
                MODE_NAME, MODE_VALUE: begin
                    if (s_rx_byte == CHR_LBRACK) begin
                        // restart the frame, partial record is lost
                        mode_next       = MODE_NAME;
                        name_accum_next = '0;
                        name_len_next   = '0;
                        captured_next   = '0;
                        value_next      = '0;
                    end else if (s_rx_byte == CHR_RBRACK) begin
                        mode_next = MODE_OUTSIDE;
                    end else if (s_rx_byte == CHR_COLON) begin
                        captured_next   = name_accum_reg;
                        name_accum_next = '0;
                        name_len_next   = '0;
                        mode_next       = MODE_VALUE;
                    end else if (s_rx_byte == CHR_SEMI) begin
                        // commit; name bytes already collected carry over
                        push       = 1'b1;
                        value_next = '0;
                        mode_next  = MODE_NAME;
                    end else if (s_rx_byte == CHR_NUL) begin
                        mode_next = mode_reg;
                    end else if (mode_reg == MODE_VALUE) begin
                        value_next = value_reg * 32'd10 + {24'd0, s_rx_byte}
                                     - {24'd0, CHR_ZERO};
                    end else if (name_len_reg < NAME_LEN_W'(NAME_CHARS)) begin
                        name_accum_next[name_len_reg[2:0]*BYTE_W +: BYTE_W] = s_rx_byte;
                        name_len_next = name_len_reg + NAME_LEN_W'(1);
                    end
                end
                default: begin
                    mode_next = MODE_OUTSIDE;
                end
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_OUTSIDE;
            name_accum_reg <= '0;
            name_len_reg   <= '0;
            captured_reg   <= '0;
            value_reg      <= '0;
        end else begin
            mode_reg       <= mode_next;
            name_accum_reg <= name_accum_next;
            name_len_reg   <= name_len_next;
            captured_reg   <= captured_next;
            value_reg      <= value_next;
        end
    end

endmodule

// ----- src/kvft_queue.sv -----
// two entry record queue between parser and table engine
`timescale 1ns / 1ps

module kvft_queue
    import kvft_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  kvft_req_t push_data,
    output logic      full,
    output logic      q_valid,
    input  logic      pop,
    output kvft_req_t q_data
);

    localparam int DEPTH = 2;
    localparam int CNT_W = 2;

    kvft_req_t        slots_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_data  = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/kvft_back.sv -----
// table engine: linear name search in ram, update, append or drop when full, result register
`timescale 1ns / 1ps

module kvft_back
    import kvft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               pop,
    input  kvft_req_t          q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOT_W-1:0]  m_slot,
    output logic               m_is_new,
    output logic               m_dropped,
    output logic [NAME_W-1:0]  m_record_name,
    output logic [VALUE_W-1:0] m_record_value,
    output logic [COUNT_W-1:0] m_entry_count
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = NAME_W + VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    state_t             state_reg, state_next;
    kvft_req_t          req_reg, req_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;

    logic               m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               is_new_reg, is_new_next;
    logic               dropped_reg, dropped_next;
    logic [NAME_W-1:0]  name_reg, name_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0] ecount_reg, ecount_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    kvft_entry_t        wr_entry;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;
    kvft_entry_t        rd_entry;
    logic               out_free;
    logic               name_match;
    logic               last_entry;

    // entry table, valid region tracked by count_reg
    kvft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_entry   = kvft_entry_t'(rd_data);
    assign out_free   = !m_valid_reg || m_ready;
    assign name_match = (rd_entry.name == req_reg.name);
    assign last_entry = (CNT_W'(cmp_idx_reg) == count_reg - CNT_W'(1));

    assign wr_entry.name  = req_reg.name;
    assign wr_entry.value = req_reg.value;

    // sequencer: pop record, scan entries one per cycle, then commit
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        slot_next      = slot_reg;
        is_new_next    = is_new_reg;
        dropped_next   = dropped_reg;
        name_next      = name_reg;
        value_next     = value_reg;
        ecount_next    = ecount_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = hit_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop            = 1'b1;
                    req_next       = q_data;
                    rd_idx_next    = '0;
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                    if (count_reg == '0) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // read address issued now, compared in the cycle after
                rd_en          = 1'b1;
                cmp_idx_next   = rd_idx_reg;
                cmp_valid_next = 1'b1;
                rd_idx_next    = rd_idx_reg + IDX_W'(1);
                if (cmp_valid_reg) begin
                    if (name_match) begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        state_next   = ST_RESULT;
                    end else if (last_entry) begin
                        hit_next   = 1'b0;
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    name_next    = req_reg.name;
                    value_next   = req_reg.value;
                    if (hit_reg) begin
                        wr_en        = 1'b1;
                        wr_addr      = hit_idx_reg;
                        slot_next    = SLOT_W'(hit_idx_reg);
                        is_new_next  = 1'b0;
                        dropped_next = 1'b0;
                        ecount_next  = COUNT_W'(count_reg);
                    end else if (count_reg < CNT_W'(TABLE_ENTRIES)) begin
                        // append a new name at the end of the table
                        wr_en        = 1'b1;
                        wr_addr      = count_reg[IDX_W-1:0];
                        slot_next    = SLOT_W'(count_reg);
                        is_new_next  = 1'b1;
                        dropped_next = 1'b0;
                        count_next   = count_reg + CNT_W'(1);
                        ecount_next  = COUNT_W'(count_reg + CNT_W'(1));
                    end else begin
                        slot_next    = '0;
                        is_new_next  = 1'b0;
                        dropped_next = 1'b1;
                        ecount_next  = COUNT_W'(count_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            m_valid_reg   <= m_valid_next;
        end
        req_reg     <= req_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        slot_reg    <= slot_next;
        is_new_reg  <= is_new_next;
        dropped_reg <= dropped_next;
        name_reg    <= name_next;
        value_reg   <= value_next;
        ecount_reg  <= ecount_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_slot         = slot_reg;
    assign m_is_new       = is_new_reg;
    assign m_dropped      = dropped_reg;
    assign m_record_name  = name_reg;
    assign m_record_value = value_reg;
    assign m_entry_count  = ecount_reg;

endmodule

// ----- src/keyvalue_frame_table_update.sv -----
// top level of the key/value frame table: parser, record queue, table engine
// throughput: one byte per cycle while the record queue has room; each record
//   holds the table engine while it searches the table (one ram read a cycle)
// reset: parser leaves any frame, queue and output empty, table count cleared
`timescale 1ns / 1ps

module keyvalue_frame_table_update
    import kvft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int NAME_CHARS    = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOT_W-1:0]  m_slot,
    output logic               m_is_new,
    output logic               m_dropped,
    output logic [NAME_W-1:0]  m_record_name,
    output logic signed [VALUE_W-1:0] m_record_value,
    output logic [COUNT_W-1:0] m_entry_count
);

    logic         push;
    kvft_req_t    push_data;
    logic         q_full;
    logic         q_valid;
    logic         pop;
    kvft_req_t    q_data;
    logic [VALUE_W-1:0] value_bits;

    // byte parser
    kvft_front #(
        .NAME_CHARS (NAME_CHARS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // record queue
    kvft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    // table engine
    kvft_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .pop            (pop),
        .q_data         (q_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot         (m_slot),
        .m_is_new       (m_is_new),
        .m_dropped      (m_dropped),
        .m_record_name  (m_record_name),
        .m_record_value (value_bits),
        .m_entry_count  (m_entry_count)
    );

    assign m_record_value = $signed(value_bits);

endmodule

// ----- tb/sv/kvft_update_checker.sv -----
// checker for the key/value frame table: tracks parser and table state, compares each update
`timescale 1ns / 1ps

module kvft_update_checker
    import kvft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int NAME_CHARS    = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [BYTE_W-1:0]  s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [SLOT_W-1:0]  m_slot,
    input  logic               m_is_new,
    input  logic               m_dropped,
    input  logic [NAME_W-1:0]  m_record_name,
    input  logic signed [VALUE_W-1:0] m_record_value,
    input  logic [COUNT_W-1:0] m_entry_count,
    output int                 mismatches,
    output int                 outstanding
);

    typedef enum logic [1:0] {
        SCAN_OUTSIDE,
        SCAN_NAME,
        SCAN_VALUE
    } scan_mode_t;

    // one table update as the block should report it
    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic               is_new;
        logic               dropped;
        logic [NAME_W-1:0]  name;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } table_update_t;

    // mirrored parser state
    scan_mode_t         scan_mode;
    logic [NAME_W-1:0]  name_acc;
    int                 name_len;
    logic [NAME_W-1:0]  cap_name;
    logic [VALUE_W-1:0] val_acc;

    // mirrored table
    logic [NAME_W-1:0]  tbl_names [TABLE_ENTRIES];
    logic [VALUE_W-1:0] tbl_values [TABLE_ENTRIES];
    int                 tbl_used;

    table_update_t      pending_updates [$];
    table_update_t      want;

    task automatic open_frame();
        scan_mode = SCAN_NAME;
        name_acc  = '0;
        name_len  = 0;
        cap_name  = '0;
        val_acc   = '0;
    endtask

    // search, then update in place, append, or drop when full
    task automatic commit_record();
        table_update_t u;
        int hit;
        int i;
        hit = -1;
        for (i = 0; i < tbl_used; i++) begin
            if (hit < 0 && tbl_names[i] == cap_name) hit = i;
        end
        u.slot    = '0;
        u.is_new  = 1'b0;
        u.dropped = 1'b0;
        u.name    = cap_name;
        u.value   = val_acc;
        if (hit >= 0) begin
            tbl_values[hit] = val_acc;
            u.slot = hit[SLOT_W-1:0];
        end else if (tbl_used < TABLE_ENTRIES) begin
            tbl_names[tbl_used]  = cap_name;
            tbl_values[tbl_used] = val_acc;
            u.slot   = tbl_used[SLOT_W-1:0];
            u.is_new = 1'b1;
            tbl_used++;
        end else begin
            u.dropped = 1'b1;
        end
        u.count = tbl_used[COUNT_W-1:0];
        pending_updates.push_back(u);
    endtask

    // advance the parser by one received byte
    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        if (scan_mode == SCAN_OUTSIDE) begin
            if (b == CHR_LBRACK) open_frame();
        end else if (b == CHR_LBRACK) begin
            open_frame();
        end else if (b == CHR_RBRACK) begin
            scan_mode = SCAN_OUTSIDE;
        end else if (b == CHR_COLON) begin
            cap_name  = name_acc;
            name_acc  = '0;
            name_len  = 0;
            scan_mode = SCAN_VALUE;
        end else if (b == CHR_SEMI) begin
            commit_record();
            val_acc   = '0;
            scan_mode = SCAN_NAME;
        end else if (b == CHR_NUL) begin
            // nul bytes are skipped inside a frame
        end else if (scan_mode == SCAN_VALUE) begin
            val_acc = val_acc * 32'd10 + ({24'd0, b} - 32'd48);
        end else if (name_len < NAME_CHARS) begin
            name_acc[8*name_len +: 8] = b;
            name_len++;
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", field, exp_v, got_v);
            mismatches++;
        end
    endtask

    // watch both channels; results are checked before the same edge's input is absorbed
    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode = SCAN_OUTSIDE;
            name_acc  = '0;
            name_len  = 0;
            cap_name  = '0;
            val_acc   = '0;
            tbl_used  = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_names[i]  = '0;
                tbl_values[i] = '0;
            end
            pending_updates.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_updates.size() == 0) begin
                    $error("update item with none outstanding: slot %0d name %0h",
                           m_slot, m_record_name);
                    mismatches++;
                end else begin
                    want = pending_updates.pop_front();
                    check_field("slot", 64'(want.slot), 64'(m_slot));
                    check_field("is_new", 64'(want.is_new), 64'(m_is_new));
                    check_field("dropped", 64'(want.dropped), 64'(m_dropped));
                    check_field("record_name", want.name, m_record_name);
                    check_field("record_value", 64'(want.value),
                                64'($unsigned(m_record_value)));
                    check_field("entry_count", 64'(want.count), 64'(m_entry_count));
                end
            end
            if (s_valid && s_ready) absorb_byte(s_rx_byte);
        end
        outstanding <= pending_updates.size();
    end

endmodule

// ----- tb/sv/keyvalue_frame_table_update_test.sv -----
// top of the key/value frame table test: stimulus, handshakes, timeout and verdict
`timescale 1ns / 1ps

module keyvalue_frame_table_update_test;
    import kvft_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int NAME_CHARS    = 8;
    localparam int RANDOM_BYTES  = 2000;
    localparam int NAME_POOL     = 100;
    localparam int POOL_MAX_LEN  = 10;
    localparam int LONG_STALL    = 800;
    localparam int DRAIN_CYCLES  = 150;
    localparam int CYCLE_LIMIT   = 1000000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [SLOT_W-1:0]  m_slot;
    logic               m_is_new;
    logic               m_dropped;
    logic [NAME_W-1:0]  m_record_name;
    logic signed [VALUE_W-1:0] m_record_value;
    logic [COUNT_W-1:0] m_entry_count;

    int fault_count;
    int updates_owed;
    int cycle_count = 0;
    bit hold_off = 1'b0;

    logic [BYTE_W-1:0] byte_stream [$];
    logic [BYTE_W-1:0] pool_chars [NAME_POOL][POOL_MAX_LEN];
    int                pool_len [NAME_POOL];

    always #4 aclk = ~aclk;

    keyvalue_frame_table_update #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NAME_CHARS   (NAME_CHARS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_is_new      (m_is_new),
        .m_dropped     (m_dropped),
        .m_record_name (m_record_name),
        .m_record_value(m_record_value),
        .m_entry_count (m_entry_count)
    );

    kvft_update_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NAME_CHARS   (NAME_CHARS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_is_new      (m_is_new),
        .m_dropped     (m_dropped),
        .m_record_name (m_record_name),
        .m_record_value(m_record_value),
        .m_entry_count (m_entry_count),
        .mismatches    (fault_count),
        .outstanding   (updates_owed)
    );

    // any byte that the parser treats as a plain name or value char
    function automatic logic [BYTE_W-1:0] pick_plain_char();
        logic [BYTE_W-1:0] c;
        c = BYTE_W'($urandom_range(1, 255));
        while (c == CHR_LBRACK || c == CHR_RBRACK || c == CHR_COLON || c == CHR_SEMI)
            c = BYTE_W'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic push_text(input string s);
        foreach (s[i]) byte_stream.push_back(s[i]);
    endtask

    // well-formed frame with records drawn from the name pool
    task automatic push_frame();
        int n;
        int k;
        int digits;
        byte_stream.push_back(CHR_LBRACK);
        repeat ($urandom_range(1, 5)) begin
            n = $urandom_range(0, NAME_POOL - 1);
            for (k = 0; k < pool_len[n]; k++) byte_stream.push_back(pool_chars[n][k]);
            byte_stream.push_back(CHR_COLON);
            digits = $urandom_range(0, 12);
            for (k = 0; k < digits; k++) begin
                if ($urandom_range(0, 15) == 0)
                    byte_stream.push_back(pick_plain_char());
                else
                    byte_stream.push_back(BYTE_W'(CHR_ZERO + $urandom_range(0, 9)));
            end
            byte_stream.push_back(CHR_SEMI);
        end
        if ($urandom_range(0, 3) != 0) byte_stream.push_back(CHR_RBRACK);
    endtask

    // short run weighted toward delimiters and nul bytes
    task automatic push_broken();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 6))
                0: byte_stream.push_back(CHR_LBRACK);
                1: byte_stream.push_back(CHR_RBRACK);
                2: byte_stream.push_back(CHR_COLON);
                3: byte_stream.push_back(CHR_SEMI);
                4: byte_stream.push_back(CHR_NUL);
                5: byte_stream.push_back(BYTE_W'(CHR_ZERO + $urandom_range(0, 9)));
                default: byte_stream.push_back(pick_plain_char());
            endcase
        end
    endtask

    // build the byte stream: directed cases, then random frames, breakage and noise
    task automatic build_stream();
        int n;
        int k;
        int target;
        int pick;
        for (n = 0; n < NAME_POOL; n++) begin
            pool_len[n] = ($urandom_range(0, 4) == 0) ? $urandom_range(9, POOL_MAX_LEN)
                                                      : $urandom_range(1, NAME_CHARS);
            for (k = 0; k < POOL_MAX_LEN; k++) pool_chars[n][k] = pick_plain_char();
        end
        // frame start, nul skipped, name truncated past eight chars, new record
        byte_stream.push_back(CHR_LBRACK);
        byte_stream.push_back(CHR_NUL);
        push_text("abcdefghZ:99;");
        // colon with empty name, all-ones byte as a value digit
        byte_stream.push_back(CHR_COLON);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(CHR_SEMI);
        // semicolon in name mode recommits the held name with zero
        byte_stream.push_back(CHR_SEMI);
        // nested start, frame end dropping a partial record, byte outside ignored
        push_text("x[y];");
        target = byte_stream.size() + RANDOM_BYTES;
        while (byte_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                push_frame();
            end else if (pick < 92) begin
                push_broken();
            end else begin
                repeat ($urandom_range(1, 6))
                    byte_stream.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // sender: random gaps, burst stretches, one pause until all updates are back
    initial begin : byte_source
        int idx;
        int gap;
        int quiet_left;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        quiet_left = 0;
        build_stream();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (idx = 0; idx < byte_stream.size(); idx++) begin
            if (idx == byte_stream.size() / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (updates_owed != 0) @(posedge aclk);
            end
            if (hold_off || quiet_left > 0) begin
                if (quiet_left > 0) quiet_left--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 39) == 0) quiet_left = 30;
                gap = $urandom_range(0, 7);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_rx_byte <= byte_stream[idx];
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (updates_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("keyvalue_frame_table_update_test: done, clean");
        else
            $display("keyvalue_frame_table_update_test: done, errors");
        $finish;
    end

    // receiver: random stalls, burst stretches, one long hold-off to back up the block
    initial begin : update_sink
        int gap;
        int taken;
        int quiet_left;
        m_ready <= 1'b0;
        taken      = 0;
        quiet_left = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (quiet_left > 0) begin
                quiet_left--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 39) == 0) quiet_left = 30;
                gap = $urandom_range(0, 7);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if (taken == 20) begin
                hold_off = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                hold_off = 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("keyvalue_frame_table_update_test: done, errors");
            $finish;
        end
    end

endmodule
